// ===== src/bmrq_pkg.sv =====
`timescale 1ns / 1ps

package bmrq_pkg;

  // Default sizing
  localparam int LEVELS_DEF     = 4;
  localparam int FIFO_DEPTH_DEF = 16;

  // Operation codes carried in the mode field
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TAKE   = 2'd1,
    OP_CHANGE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_IDLE   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  // Input beat
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] task_id;
    logic [1:0] level;
    logic [1:0] new_level;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] task_id_out;
    logic       any_ready;
    logic       higher_ready;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] task_id;
    logic [1:0] level;
    logic [1:0] new_level;
    logic       lvl_ok;
    logic       nlvl_ok;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_TAKE_WAIT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUSH,
    S_RESULT
  } state_t;

endpackage

// ===== src/bmrq_queue.sv =====
`timescale 1ns / 1ps

// Two-entry queue, any packed payload
module bmrq_queue #(
  parameter type T = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  T     wdata,
  input  logic pop,
  output logic empty,
  output T     rdata
);

  T           mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

// ===== src/bmrq_front.sv =====
`timescale 1ns / 1ps

// Front end: takes input beats, checks level ranges, queues commands
module bmrq_front import bmrq_pkg::*; #(
  parameter int LEVELS = LEVELS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  input  logic  cmd_pop,
  output logic  cmd_empty,
  output cmd_t  cmd
);

  cmd_t cls;

  // Classify the incoming beat
  always_comb begin
    cls.op        = op_t'(item.mode);
    cls.task_id   = item.task_id;
    cls.level     = item.level;
    cls.new_level = item.new_level;
    cls.lvl_ok    = (32'(item.level) < LEVELS);
    cls.nlvl_ok   = (32'(item.new_level) < LEVELS);
  end

  bmrq_queue #(.T(cmd_t)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cls),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd)
  );

endmodule

// ===== src/bmrq_back.sv =====
`timescale 1ns / 1ps

// Back end: per-level FIFOs in one task memory, executes one command at a time
module bmrq_back import bmrq_pkg::*; #(
  parameter int LEVELS     = LEVELS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       idle_task_we,
  input  logic [7:0] idle_task,
  input  logic       cmd_empty,
  output logic       cmd_pop,
  input  cmd_t       cmd,
  input  logic       res_full,
  output logic       res_push,
  output result_t    res
);

  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = $clog2(LEVELS * FIFO_DEPTH);
  localparam int NE = LEVELS * FIFO_DEPTH;

  state_t         state;
  state_t         state_next;
  cmd_t           cur;
  logic [LW-1:0]  lvl_i;
  logic [LW-1:0]  nlvl_i;
  logic [LW-1:0]  top_w;
  logic [PW-1:0]  idx;
  status_t        status_r;
  logic [7:0]     tout_r;
  logic [7:0]     idle_id;
  logic [PW-1:0]  head  [LEVELS];
  logic [CW-1:0]  count [LEVELS];
  logic [LEVELS-1:0] ready;
  logic [LEVELS-1:0] below;

  // Task memory
  logic [7:0]     mem [NE];
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     rdata;

  logic           add_ok;
  logic           absent_now;
  logic           more;
  logic           hit;
  logic           tgt_ok;

  // Memory address of position pos in level l
  function automatic logic [AW-1:0] slot(logic [LW-1:0] l, logic [PW-1:0] pos);
    logic [PW:0]   s;
    logic [AW-1:0] base;
    s = {1'b0, head[l]} + {1'b0, pos};
    if (s >= (PW+1)'(FIFO_DEPTH)) s = s - (PW+1)'(FIFO_DEPTH);
    base = AW'(l) * AW'(FIFO_DEPTH);
    return base + AW'(s);
  endfunction

  // Level flags and lowest ready level
  always_comb begin
    top_w = '0;
    for (int k = LEVELS - 1; k >= 0; k--) begin
      ready[k] = (count[k] != '0);
      below[k] = (k < int'(cur.level));
      if (count[k] != '0) top_w = LW'(k);
    end
  end

  // Decision terms
  assign add_ok     = cur.lvl_ok && (count[lvl_i] < CW'(FIFO_DEPTH));
  assign absent_now = !cur.lvl_ok || (count[lvl_i] == '0);
  assign more       = (({1'b0, idx} + (PW+1)'(1)) < (PW+1)'(count[lvl_i]));
  assign hit        = (rdata == cur.task_id);
  assign tgt_ok     = cur.nlvl_ok &&
                      ((nlvl_i == lvl_i) || (count[nlvl_i] < CW'(FIFO_DEPTH)));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (!cmd_empty) state_next = S_EXEC;
      S_EXEC: begin
        unique case (cur.op)
          OP_TAKE:   state_next = (|ready) ? S_TAKE_WAIT : S_RESULT;
          OP_CHANGE: state_next = absent_now ? S_RESULT : S_SRCH_RD;
          default:   state_next = S_RESULT;
        endcase
      end
      S_TAKE_WAIT: state_next = S_RESULT;
      S_SRCH_RD:   state_next = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (hit) state_next = tgt_ok ? S_MOVE_RD : S_RESULT;
        else if (more) state_next = S_SRCH_RD;
        else state_next = S_RESULT;
      end
      S_MOVE_RD: state_next = more ? S_MOVE_WR : S_PUSH;
      S_MOVE_WR: state_next = S_MOVE_RD;
      S_PUSH:    state_next = S_RESULT;
      S_RESULT:  if (!res_full) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Outputs: memory control and handshakes
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: cmd_pop = !cmd_empty;
      S_EXEC: begin
        if (cur.op == OP_ADD && add_ok) begin
          mem_we    = 1'b1;
          mem_waddr = slot(lvl_i, PW'(count[lvl_i]));
          mem_wdata = cur.task_id;
        end
        if (cur.op == OP_TAKE && (|ready)) begin
          mem_re    = 1'b1;
          mem_raddr = slot(top_w, '0);
        end
      end
      S_SRCH_RD: begin
        mem_re    = 1'b1;
        mem_raddr = slot(lvl_i, idx);
      end
      S_MOVE_RD: begin
        mem_re    = more;
        mem_raddr = slot(lvl_i, PW'({1'b0, idx} + (PW+1)'(1)));
      end
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = slot(lvl_i, idx);
        mem_wdata = rdata;
      end
      S_PUSH: begin
        mem_we    = 1'b1;
        mem_waddr = slot(nlvl_i, PW'(count[nlvl_i]));
        mem_wdata = cur.task_id;
      end
      S_RESULT: res_push = !res_full;
      default: ;
    endcase
  end

  // Result beat, flags taken from the state left by the operation
  always_comb begin
    res.status       = status_r;
    res.task_id_out  = tout_r;
    res.any_ready    = |ready;
    res.higher_ready = |(ready & below);
  end

  // Task memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // Control state: sequencer, heads, counts, idle id
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idle_id <= '0;
      for (int k = 0; k < LEVELS; k++) begin
        head[k]  <= '0;
        count[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (idle_task_we) idle_id <= idle_task;
      unique case (state)
        S_EXEC: begin
          if (cur.op == OP_ADD && add_ok) count[lvl_i] <= count[lvl_i] + CW'(1);
          if (cur.op == OP_TAKE && (|ready)) begin
            head[top_w]  <= (head[top_w] == PW'(FIFO_DEPTH - 1)) ? '0
                                                                 : head[top_w] + PW'(1);
            count[top_w] <= count[top_w] - CW'(1);
          end
        end
        S_MOVE_RD: if (!more) count[lvl_i] <= count[lvl_i] - CW'(1);
        S_PUSH:    count[nlvl_i] <= count[nlvl_i] + CW'(1);
        default: ;
      endcase
    end
  end

  // Command payload and result fields
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (!cmd_empty) begin
          cur      <= cmd;
          lvl_i    <= LW'(cmd.level);
          nlvl_i   <= LW'(cmd.new_level);
          idx      <= '0;
          status_r <= ST_DONE;
          tout_r   <= '0;
        end
      end
      S_EXEC: begin
        unique case (cur.op)
          OP_ADD:    if (!add_ok) status_r <= ST_FULL;
          OP_TAKE: begin
            if (!(|ready)) begin
              status_r <= ST_IDLE;
              tout_r   <= idle_id;
            end
          end
          OP_CHANGE: if (absent_now) status_r <= ST_ABSENT;
          default: ;
        endcase
      end
      S_TAKE_WAIT: tout_r <= rdata;
      S_SRCH_CMP: begin
        if (hit) begin
          if (!tgt_ok) status_r <= ST_FULL;
        end else if (more) begin
          idx <= idx + PW'(1);
        end else begin
          status_r <= ST_ABSENT;
        end
      end
      S_MOVE_WR: idx <= idx + PW'(1);
      default: ;
    endcase
  end

endmodule

// ===== src/bitmap_multilevel_ready_queue.sv =====
`timescale 1ns / 1ps

// Multilevel ready queue: one FIFO of task ids per level (level 0 most urgent)
// kept in a single task memory, with a flag per non-empty level. Input beats
// pass through a two-entry command queue; results leave through a two-entry
// result queue, so either side may stall on its own. The back end runs one
// command at a time: add and query go from command pickup straight to the
// result, take waits for one memory read, and a level change searches the
// level entry by entry, compacts the entries behind the found task and
// pushes it onto the new level, paced by the single memory read port.
// A change that finds nothing ends after the search. The user must write the
// idle task id by idle_task_we only while the block is quiet (not enforced).
module bitmap_multilevel_ready_queue import bmrq_pkg::*; #(
  parameter int LEVELS     = LEVELS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  item_t      item,
  output logic       empty,
  input  logic       pop,
  output result_t    result,
  input  logic       idle_task_we,
  input  logic [7:0] idle_task
);

  logic    cmd_pop;
  logic    cmd_empty;
  cmd_t    cmd;
  logic    res_push;
  logic    res_full;
  result_t res;

  bmrq_front #(.LEVELS(LEVELS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd       (cmd)
  );

  bmrq_back #(.LEVELS(LEVELS), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .idle_task_we (idle_task_we),
    .idle_task    (idle_task),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .res_full     (res_full),
    .res_push     (res_push),
    .res          (res)
  );

  // Result queue
  bmrq_queue #(.T(result_t)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule
